// ===== sv/bchf_pkg.sv =====
// Shared types and constants for the border-connected hole fill block.
package bchf_pkg;

  localparam int ROW_W        = 64;  // width of a row on the ports
  localparam int CFG_W        = 7;   // width of the column-count register
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } in_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] result_bits;
    logic             last_out;
    logic             rows_dropped;
  } out_req_t;

  // Controls broadcast to every row lane.
  typedef struct packed {
    logic seed;   // mask stored row, plant border seeds
    logic step;   // one propagation step
    logic shift;  // move reached rows toward lane 0 for output
  } lane_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SEED,
    S_FLOOD,
    S_EMIT
  } state_t;

endpackage

// ===== sv/bchf_lane.sv =====
// One row lane: stored open row, reached row, and its propagation step.
module bchf_lane #(
  parameter int W = bchf_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  bchf_pkg::lane_ctl_t ctl,
  input  logic               load_en,
  input  logic [W-1:0]       row_in,
  input  logic               keep,     // lane holds a row of this grid
  input  logic               border,   // first or last row of the grid
  input  logic [W-1:0]       col_mask,
  input  logic [W-1:0]       edge_mask,
  input  logic [W-1:0]       up,       // reached row of lane r-1
  input  logic [W-1:0]       down,     // reached row of lane r+1
  input  logic [W-1:0]       shift_in,
  output logic [W-1:0]       reached,
  output logic               changed
);
  import bchf_pkg::*;

  logic [W-1:0] open_row;
  logic [W-1:0] grow;
  logic [W-1:0] seed_mask;
  logic [W-1:0] masked;

  assign masked    = open_row & col_mask;
  assign seed_mask = border ? col_mask : edge_mask;
  assign grow      = (reached | (reached << 1) | (reached >> 1) | up | down) & open_row;

  always_ff @(posedge clk) begin
    if (load_en) begin
      open_row <= row_in;
    end else if (ctl.seed) begin
      open_row <= keep ? masked : '0;
    end

    if (ctl.seed) begin
      reached <= keep ? (masked & seed_mask) : '0;
      changed <= 1'b1;
    end else if (ctl.step) begin
      reached <= grow;
      changed <= (grow != reached);
    end else if (ctl.shift) begin
      reached <= shift_in;
    end
  end

endmodule

// ===== sv/bchf_merge.sv =====
// Merge stage: combines lane change flags into a registered "settled" flag.
module bchf_merge #(
  parameter int LANES = bchf_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bchf_pkg::lane_ctl_t ctl,
  input  logic [LANES-1:0]   lane_changed,
  output logic               settled
);
  import bchf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.seed) begin
      settled <= 1'b0;
    end else if (ctl.step) begin
      settled <= ~(|lane_changed);
    end
  end

endmodule

// ===== sv/border_connected_hole_fill.sv =====
// Top level: border-connected hole fill over a grid of up to MAX_ROWS x MAX_COLS.
// Rows load one per cycle; after the last row come a seed step, then flood steps until
//   no lane changes (more of them for a longer open path from the border), then one
//   stored row per cycle on output while out_stall is low. Input is stalled from the
//   last row until output ends. Reset (rst, synchronous) empties the grid, clears the
//   overflow flag and sets cols to 64.
module border_connected_hole_fill #(
  parameter int MAX_ROWS = bchf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bchf_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bchf_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bchf_pkg::in_req_t            in_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bchf_pkg::out_req_t           out_req
);
  import bchf_pkg::*;

  localparam int CW = $clog2(MAX_ROWS + 1);  // row count, 0..MAX_ROWS
  localparam int MW = $clog2(MAX_COLS + 1);  // effective columns, 1..MAX_COLS

  state_t          state, state_next;
  logic [CFG_W-1:0] cols;
  logic [CW-1:0]   row_count;
  logic [CW-1:0]   emit_idx;
  logic [CW-1:0]   last_idx;
  logic            overflow;
  logic            in_acc;
  logic            out_acc;
  logic            settled;
  lane_ctl_t       ctl;

  logic [MW-1:0]       eff_cols;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] edge_mask;

  logic [MAX_COLS-1:0] reached [MAX_ROWS];
  logic [MAX_ROWS-1:0] lane_changed;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state != S_LOAD);
  assign last_idx = row_count - CW'(1);

  // Column count register; 0 acts as 1, anything above MAX_COLS as MAX_COLS.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= COLS_RESET;
    end else if (cfg_wr_en) begin
      cols <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cols == '0) begin
      eff_cols = MW'(1);
    end else if (cols > CFG_W'(MAX_COLS)) begin
      eff_cols = MW'(MAX_COLS);
    end else begin
      eff_cols = MW'(cols);
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j]  = (MW'(j) < eff_cols);
      edge_mask[j] = (j == 0) || (MW'(j) == eff_cols - MW'(1));
    end
  end

  // Sequencer: load rows, seed borders, flood until settled, emit rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    out_valid  = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (in_acc && in_req.last_row) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        ctl.seed   = 1'b1;
        state_next = S_FLOOD;
      end
      S_FLOOD: begin
        // Stepping a settled grid changes nothing, so the exit cycle may step too.
        ctl.step = 1'b1;
        if (settled) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        ctl.shift = out_acc;
        if (out_acc && emit_idx == last_idx) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Row count, overflow flag and output row index.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      overflow  <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (in_acc) begin
        if (row_count < CW'(MAX_ROWS)) begin
          row_count <= row_count + CW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (state == S_SEED) begin
        emit_idx <= '0;
      end else if (out_acc) begin
        emit_idx <= emit_idx + CW'(1);
        if (emit_idx == last_idx) begin
          row_count <= '0;
          overflow  <= 1'b0;
        end
      end
    end
  end

  // Row lanes: lane r holds grid row r; neighbors are wired at fixed places.
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_lane
    logic [MAX_COLS-1:0] up_row;
    logic [MAX_COLS-1:0] down_row;
    logic                load_en;
    logic                keep;
    logic                border;

    if (r == 0) begin : g_top
      assign up_row = '0;
    end else begin : g_up
      assign up_row = reached[r-1];
    end
    if (r == MAX_ROWS - 1) begin : g_bot
      assign down_row = '0;
    end else begin : g_down
      assign down_row = reached[r+1];
    end

    assign load_en = in_acc && (row_count == CW'(r));
    assign keep    = (CW'(r) < row_count);
    assign border  = (r == 0) || (CW'(r) == last_idx);

    bchf_lane #(.W(MAX_COLS)) u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .load_en   (load_en),
      .row_in    (in_req.row_bits[MAX_COLS-1:0]),
      .keep      (keep),
      .border    (border),
      .col_mask  (col_mask),
      .edge_mask (edge_mask),
      .up        (up_row),
      .down      (down_row),
      .shift_in  (down_row),
      .reached   (reached[r]),
      .changed   (lane_changed[r])
    );
  end

  bchf_merge #(.LANES(MAX_ROWS)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .lane_changed (lane_changed),
    .settled      (settled)
  );

  // Output request: lane 0 holds the current row as reached rows shift down.
  always_comb begin
    out_req.result_bits  = ROW_W'(reached[0]);
    out_req.last_out     = (emit_idx == last_idx);
    out_req.rows_dropped = overflow;
  end

endmodule

// ===== tb/sv/tb_border_connected_hole_fill.sv =====
// Self-checking testbench for the border-connected hole fill block.
`timescale 1ns / 1ps

module tb_border_connected_hole_fill;
  import bchf_pkg::*;

  localparam int      CLK_HALF_NS   = 2;
  localparam int      RANDOM_ROWS   = 230;
  localparam int      MAX_GAP       = 10;
  localparam longint  RUN_LIMIT_NS  = 64'd16_000_000;  // far above the slowest legal run

  // Row fill patterns used by the random part.
  typedef enum int {
    PAT_EVEN,    // about half the cells open
    PAT_DENSE,   // about three quarters open
    PAT_SPARSE,  // about one quarter open
    PAT_OPEN     // nearly all open
  } pattern_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the grid, the overflow flag and the
  // column count, floods the grid when the last row is taken, and holds the
  // rows the block must emit, oldest first.
  // ---------------------------------------------------------------------------
  class hole_fill_scoreboard;
    logic [ROW_W-1:0] grid_rows[$];
    bit               rows_lost;
    logic [CFG_W-1:0] cols_cfg = COLS_RESET;
    out_req_t         expected_rows[$];
    int               errors;
    int               checked;
    int               grids;

    function void set_columns(logic [CFG_W-1:0] value);
      cols_cfg = value;
    endfunction

    function void note_row(in_req_t req);
      if (grid_rows.size() < MAX_ROWS_DEF)
        grid_rows.push_back(req.row_bits);
      else
        rows_lost = 1'b1;
      if (req.last_row) begin
        fill_grid();
        grid_rows.delete();
        rows_lost = 1'b0;
        grids++;
      end
    endfunction

    // Iterative border flood; same fixed point as a depth-first walk.
    function void fill_grid();
      int               n;
      int               m;
      bit               changed;
      logic [ROW_W-1:0] cm;
      logic [ROW_W-1:0] side;
      logic [ROW_W-1:0] cur;
      logic [ROW_W-1:0] grow;
      logic [ROW_W-1:0] nxt;
      logic [ROW_W-1:0] reach[$];
      out_req_t         exp_row;
      n = grid_rows.size();
      m = int'(cols_cfg);
      if (m < 1) m = 1;
      if (m > MAX_COLS_DEF) m = MAX_COLS_DEF;
      cm   = (m >= ROW_W) ? '1 : ((ROW_W'(1) << m) - ROW_W'(1));
      side = ROW_W'(1) | (ROW_W'(1) << (m - 1));
      for (int r = 0; r < n; r++) begin
        grid_rows[r] &= cm;
        reach.push_back(grid_rows[r] & ((r == 0 || r == n - 1) ? cm : side));
      end
      do begin
        changed = 1'b0;
        for (int r = 0; r < n; r++) begin
          cur  = reach[r];
          grow = cur | (cur << 1) | (cur >> 1);
          if (r > 0) grow |= reach[r-1];
          if (r + 1 < n) grow |= reach[r+1];
          nxt = grow & grid_rows[r] & cm;
          if (nxt != cur) begin
            reach[r] = nxt;
            changed  = 1'b1;
          end
        end
      end while (changed);
      for (int r = 0; r < n; r++) begin
        exp_row.result_bits  = reach[r];
        exp_row.last_out     = (r == n - 1);
        exp_row.rows_dropped = rows_lost;
        expected_rows.push_back(exp_row);
      end
    endfunction

    function void check_row(out_req_t got);
      out_req_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected result row: result_bits %h last_out %0b rows_dropped %0b",
               got.result_bits, got.last_out, got.rows_dropped);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      checked++;
      if (got.result_bits !== want.result_bits) begin
        $error("result_bits: expected %h, actual %h", want.result_bits, got.result_bits);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
        errors++;
      end
      if (got.rows_dropped !== want.rows_dropped) begin
        $error("rows_dropped: expected %0b, actual %0b", want.rows_dropped, got.rows_dropped);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and its ports; every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_req_t         out_req;

  border_connected_hole_fill DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_req     (out_req)
  );

  hole_fill_scoreboard sb = new();

  int rows_sent;
  int random_rows;
  int cfg_writes;
  int in_gap_max  = MAX_GAP;  // 0 gives a stretch with no idling
  int out_gap_max = MAX_GAP;

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. All drives happen right after a rising edge with NBAs, and
  // handshakes are sampled at the edge itself, so there is no race with the DUT.
  // ---------------------------------------------------------------------------

  // Present one row request and hold it until taken. On a zero gap, valid
  // simply stays high and only the payload changes.
  task automatic send_row(input logic [ROW_W-1:0] bits, input bit last);
    int      gap;
    in_req_t req;
    gap          = $urandom_range(0, in_gap_max);
    req.row_bits = bits;
    req.last_row = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_row(req);
    rows_sent++;
  endtask

  // Result side: random stall before each request, then take it.
  task automatic drain_results();
    int gap;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_row(out_req);
    end
  endtask

  // Called on the edge that took the last row of a phase. Waits until every
  // expected row is out, then idles so the block is back in load.
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_columns(input logic [CFG_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_columns(value);
    cfg_writes++;
  endtask

  function automatic logic [ROW_W-1:0] rand_row(pattern_t pat);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (pat)
      PAT_DENSE:  return a | b;
      PAT_SPARSE: return a & b;
      PAT_OPEN:   return a | b | c;
      default:    return a;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int       grid_no;
    int       grid_rows;
    int       grids_in_phase;
    pattern_t pat;
    logic [CFG_W-1:0] cols;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // ---- directed part ----
    // Reset column count (64), no config write yet.
    send_row('1, 1'b1);                       // one-row grid: whole row is border
    send_row('0, 1'b0);                       // open runs touching either side stay,
    send_row(64'hF0F0_0000_0000_0007, 1'b0);  // the run at bits 52..55 is enclosed
    send_row('0, 1'b1);
    send_row('0, 1'b0);                       // all closed then all open
    send_row('1, 1'b1);
    send_row('1, 1'b0);                       // frame with an enclosed island
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0FF0_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('1, 1'b1);
    end_phase();

    write_columns(CFG_W'(0));                 // zero acts as a single column
    send_row(rand_row(PAT_EVEN), 1'b0);
    send_row(rand_row(PAT_OPEN), 1'b1);
    end_phase();

    write_columns(CFG_W'(127));               // above range, acts as full width
    send_row('1, 1'b0);
    send_row(rand_row(PAT_SPARSE), 1'b1);
    end_phase();

    write_columns(CFG_W'(3));                 // lone center cell of a 3x3 is a hole;
    send_row('0, 1'b0);                       // bits above column 2 are ignored
    send_row(64'hFFFF_FFFF_FFFF_FFFA, 1'b0);
    send_row('0, 1'b1);
    end_phase();

    write_columns(CFG_W'(65));
    send_row(rand_row(PAT_DENSE), 1'b1);
    end_phase();

    write_columns(CFG_W'(1));
    send_row(rand_row(PAT_EVEN), 1'b0);
    send_row(rand_row(PAT_EVEN), 1'b1);
    end_phase();

    // ---- random part ----
    grid_no = 0;
    while (random_rows < RANDOM_ROWS) begin
      case ($urandom_range(0, 4))
        0:       cols = CFG_W'(1);
        1:       cols = CFG_W'($urandom_range(2, 8));
        2:       cols = CFG_W'(64);
        3:       cols = CFG_W'($urandom_range(1, 64));
        default: cols = CFG_W'($urandom_range(0, 127));
      endcase
      write_columns(cols);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      grids_in_phase = $urandom_range(1, 3);
      repeat (grids_in_phase) begin
        // Mostly small grids; one full-height grid and one that overflows,
        // where the dropped rows include the one that carries last.
        if (grid_no == 2)
          grid_rows = MAX_ROWS_DEF;
        else if (grid_no == 5)
          grid_rows = MAX_ROWS_DEF + $urandom_range(1, 3);
        else
          grid_rows = $urandom_range(1, 8);
        pat = pattern_t'($urandom_range(0, 3));
        for (int r = 0; r < grid_rows; r++) begin
          send_row(rand_row(pat), r == grid_rows - 1);
          random_rows++;
        end
        grid_no++;
      end
      end_phase();
    end

    in_gap_max  = MAX_GAP;
    out_gap_max = MAX_GAP;
    repeat (64) @(posedge clk);  // catch any stray result rows

    $display("Drove %0d rows in %0d grids over %0d column settings; checked %0d result rows.",
             rows_sent, sb.grids, cfg_writes, sb.checked);
    $display("Grids ranged from one row to past capacity, column counts from 0 to 127.");
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== border_connected_hole_fill.f =====
sv/bchf_pkg.sv
sv/bchf_lane.sv
sv/bchf_merge.sv
sv/border_connected_hole_fill.sv
tb/sv/tb_border_connected_hole_fill.sv
